@@ design/thp_pkg.sv @@
// package for the tagged hex position parser
// character codes, object identities, window length and the hex digit decode
// no dependencies
package thp_pkg;

  localparam int WIN_LEN = 8;

  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_V     = 8'h56;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_Y     = 8'h59;
  localparam logic [7:0] CHAR_W     = 8'h57;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  localparam logic [1:0] OBJ_FRONT = 2'd0;
  localparam logic [1:0] OBJ_BACK  = 2'd1;
  localparam logic [1:0] OBJ_BALL  = 2'd2;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      diff = c - CHAR_0;
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      diff = c - CHAR_LA + HEX_TEN;
    end
    return diff[3:0];
  endfunction

endpackage

@@ design/thp_byte_if.sv @@
// request channel carrying one received byte
// depends on thp_pkg
interface thp_byte_if import thp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ design/thp_pos_if.sv @@
// request channel carrying one decoded object position
// depends on thp_pkg
interface thp_pos_if import thp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  object_id;
  logic [11:0] x_pos;
  logic [11:0] y_pos;

  modport source (output valid, output object_id, output x_pos, output y_pos, input ready);
  modport sink (input valid, input object_id, input x_pos, input y_pos, output ready);
endinterface

@@ design/thp_cell.sv @@
// one byte slot of the sliding window, shifts towards the oldest end
// depends on thp_pkg
module thp_cell import thp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] d_in,
  output logic [7:0] q,
  output logic [3:0] nib
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      q <= 8'd0;
    end else if (ctrl.shift) begin
      q <= d_in;
    end
  end

  assign nib = hex_val(q);

endmodule

@@ design/thp_top.sv @@
// channel  dir  payload                      request accepted when
// rx       in   rx_byte[7:0]                 rx.valid && rx.ready
// pos      out  object_id, x_pos, y_pos      pos.valid && pos.ready
//
// one byte per cycle while rx.ready is high; the window is a chain of eight byte cells
// that a colon clears and any other accepted byte shifts; the byte completing a result
// loads it into the output register; rx.ready is low only while a result waits there
// and pos.ready is low; synchronous reset clears the window and the output valid
// depends on thp_pkg, thp_byte_if, thp_pos_if, thp_cell
module tagged_hex_position_parser_top import thp_pkg::*; (
  input logic       clk,
  input logic       rst,
  thp_byte_if.sink  rx,
  thp_pos_if.source pos
);

  logic [7:0] win [WIN_LEN];
  logic [3:0] nib [WIN_LEN];
  logic       accept;
  logic       is_colon;
  cell_ctrl_t ctrl;
  logic       hit;
  logic [1:0] id;
  logic       load;
  logic       out_valid;
  logic       out_valid_next;
  logic [1:0] out_id;
  logic [11:0] out_x;
  logic [11:0] out_y;

  assign rx.ready   = !out_valid || pos.ready;
  assign accept     = rx.valid && rx.ready;
  assign is_colon   = rx.rx_byte == CHAR_COLON;
  assign ctrl.clear = accept && is_colon;
  assign ctrl.shift = accept && !is_colon;

  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    thp_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .d_in ((i == WIN_LEN - 1) ? rx.rx_byte : win[(i + 1) % WIN_LEN]),
      .q    (win[i]),
      .nib  (nib[i])
    );
  end

  always_comb begin
    hit = 1'b1;
    id  = OBJ_FRONT;
    if (win[0] == CHAR_C && win[1] == CHAR_B && win[2] == CHAR_E) begin
      id = OBJ_FRONT;
    end else if (win[0] == CHAR_C && win[1] == CHAR_V && win[2] == CHAR_T) begin
      id = OBJ_BACK;
    end else if (win[0] == CHAR_B && win[1] == CHAR_Y && win[2] == CHAR_W) begin
      id = OBJ_BALL;
    end else begin
      hit = 1'b0;
    end
  end

  assign load = ctrl.shift && hit;

  always_comb begin
    out_valid_next = out_valid;
    if (pos.ready) begin
      out_valid_next = 1'b0;
    end
    if (load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_id <= id;
      out_x  <= {nib[3], nib[4], nib[5]};
      out_y  <= {nib[6], nib[7], hex_val(rx.rx_byte)};
    end
  end

  assign pos.valid     = out_valid;
  assign pos.object_id = out_id;
  assign pos.x_pos     = out_x;
  assign pos.y_pos     = out_y;

`ifndef ASSERT_OFF
  a_clear_empties_window: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> (win[0] == 8'd0 && win[4] == 8'd0 && win[7] == 8'd0))
    else $error("window not cleared after colon");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> pos.valid)
    else $error("matched tag produced no result");

  a_no_bad_id: assert property (@(posedge clk) disable iff (rst)
    pos.valid |-> (pos.object_id == OBJ_FRONT || pos.object_id == OBJ_BACK ||
                   pos.object_id == OBJ_BALL))
    else $error("invalid object identity");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> (out_valid && !pos.ready))
    else $error("input stalled without a waiting result");
`endif

endmodule

@@ tb/tagged_hex_position_parser_top_test.sv @@
// testbench for tagged_hex_position_parser_top: byte stream in, decoded object positions out
// own window-based predictor, random idling on both channels, one long output hold-off
// depends on thp_pkg, thp_byte_if, thp_pos_if and the design top
module tagged_hex_position_parser_top_test;
  import thp_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int PAUSE_AT     = 450;
  localparam int HOLD_AFTER   = 20;
  localparam int HOLD_CYCLES  = 250;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    bit         pause;
    logic [7:0] b;
  } rx_plan_t;

  typedef struct packed {
    logic [1:0]  object_id;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
  } position_t;

  logic clk;
  logic rst;

  thp_byte_if rx_if ();
  thp_pos_if  pos_if ();

  tagged_hex_position_parser_top u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .pos (pos_if)
  );

  rx_plan_t   rx_plan_q[$];
  position_t  pos_expect_q[$];
  logic [7:0] recent [WIN_LEN];

  rx_plan_t   rx_head;
  logic [7:0] rx_cur;
  bit         rx_busy;
  bit         rx_calm;
  int         rx_gap;

  bit         pos_calm;
  int         pos_stall;
  int         pos_seen;
  int         hold_cnt;
  logic       hold_on;

  int         mismatches;
  int         cycles;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles++;
  end

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) begin
      return 4'(c - CHAR_0);
    end
    if (c >= CHAR_LA && c <= CHAR_LF) begin
      return 4'(c - CHAR_LA + HEX_TEN);
    end
    return 4'd0;
  endfunction

  function automatic logic [11:0] three_digit_value(input logic [7:0] a, input logic [7:0] b,
                                                    input logic [7:0] c);
    return {digit_value(a), digit_value(b), digit_value(c)};
  endfunction

  function automatic logic [7:0] tag_char(input logic [1:0] id, input int k);
    case (id)
      OBJ_FRONT: begin
        return (k == 0) ? CHAR_C : (k == 1) ? CHAR_B : CHAR_E;
      end
      OBJ_BACK: begin
        return (k == 0) ? CHAR_C : (k == 1) ? CHAR_V : CHAR_T;
      end
      default: begin
        return (k == 0) ? CHAR_B : (k == 1) ? CHAR_Y : CHAR_W;
      end
    endcase
  endfunction

  // window update and position decode for one accepted byte
  function automatic void parse_byte(input logic [7:0] c);
    logic [7:0] nine [WIN_LEN + 1];
    position_t  p;
    bit         hit;
    hit = 1'b0;
    if (c == CHAR_COLON) begin
      foreach (recent[i]) recent[i] = 8'h00;
      return;
    end
    foreach (recent[i]) nine[i] = recent[i];
    nine[WIN_LEN] = c;
    p.object_id = OBJ_FRONT;
    if (nine[0] == CHAR_C && nine[1] == CHAR_B && nine[2] == CHAR_E) begin
      p.object_id = OBJ_FRONT;
      hit = 1'b1;
    end else if (nine[0] == CHAR_C && nine[1] == CHAR_V && nine[2] == CHAR_T) begin
      p.object_id = OBJ_BACK;
      hit = 1'b1;
    end else if (nine[0] == CHAR_B && nine[1] == CHAR_Y && nine[2] == CHAR_W) begin
      p.object_id = OBJ_BALL;
      hit = 1'b1;
    end
    for (int i = 0; i < WIN_LEN; i++) recent[i] = nine[i + 1];
    if (hit) begin
      p.x_pos = three_digit_value(nine[3], nine[4], nine[5]);
      p.y_pos = three_digit_value(nine[6], nine[7], nine[8]);
      pos_expect_q.push_back(p);
    end
  endfunction

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 31) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
    mismatches++;
  endtask

  function automatic void push_byte(input logic [7:0] b);
    rx_plan_t t;
    t.pause = 1'b0;
    t.b = b;
    rx_plan_q.push_back(t);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] random_digit();
    string upper;
    int    v;
    upper = "ABCDEF";
    v = $urandom_range(0, 19);
    if (v < 10) begin
      return CHAR_0 + 8'(v);
    end else if (v < 16) begin
      return CHAR_LA + 8'(v - 10);
    end else if (v < 18) begin
      return upper[$urandom_range(0, 5)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed tagged messages, some cut short or broken by a colon, some noise
  function automatic void add_message();
    int         kind;
    logic [1:0] id;
    int         len;
    kind = $urandom_range(0, 9);
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
    if (kind == 9) begin
      repeat ($urandom_range(4, 10)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      id = 2'($urandom_range(OBJ_FRONT, OBJ_BALL));
      for (int k = 0; k < 3; k++) push_byte(tag_char(id, k));
      len = (kind >= 7) ? $urandom_range(0, 5) : 6;
      for (int k = 0; k < len; k++) push_byte(random_digit());
      if (kind == 7) begin
        push_byte(CHAR_COLON);
      end
    end
  endfunction

  function automatic void build_stimulus();
    rx_plan_t hold;
    bit       paused;
    int       total;
    paused = 1'b0;
    push_text("CBEfff000");
    push_text("CVT09aFG~");
    push_text("BYW:");
    push_byte(8'h00);
    push_byte(8'hff);
    total = rx_plan_q.size() + RANDOM_ITEMS;
    while (rx_plan_q.size() < total) begin
      if (!paused && rx_plan_q.size() >= PAUSE_AT) begin
        hold.pause = 1'b1;
        hold.b = 8'h00;
        rx_plan_q.push_back(hold);
        paused = 1'b1;
      end
      add_message();
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
      rx_if.rx_byte <= 8'h00;
      rx_busy = 1'b0;
      rx_gap = 0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        parse_byte(rx_if.rx_byte);
        rx_busy = 1'b0;
        rx_gap = draw_gap(rx_calm);
      end
      if (!rx_busy) begin
        if (rx_gap > 0) begin
          rx_gap--;
        end else if (rx_plan_q.size() > 0) begin
          if (rx_plan_q[0].pause) begin
            if (pos_expect_q.size() == 0) begin
              void'(rx_plan_q.pop_front());
            end
          end else begin
            rx_head = rx_plan_q.pop_front();
            rx_cur = rx_head.b;
            rx_busy = 1'b1;
          end
        end
      end
      rx_if.valid <= rx_busy;
      rx_if.rx_byte <= rx_cur;
    end
  end

  // long output hold-off, once
  assign hold_on = (pos_seen >= HOLD_AFTER) && (hold_cnt < HOLD_CYCLES);

  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (hold_on) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    position_t want;
    if (rst) begin
      pos_if.ready <= 1'b0;
      pos_stall = 0;
    end else begin
      if (pos_if.valid && pos_if.ready) begin
        if (pos_expect_q.size() == 0) begin
          report_mismatch("result with nothing pending, object_id", pos_if.object_id, 0);
        end else begin
          want = pos_expect_q.pop_front();
          if (pos_if.object_id !== want.object_id) begin
            report_mismatch("object_id", pos_if.object_id, want.object_id);
          end
          if (pos_if.x_pos !== want.x_pos) begin
            report_mismatch("x_pos", pos_if.x_pos, want.x_pos);
          end
          if (pos_if.y_pos !== want.y_pos) begin
            report_mismatch("y_pos", pos_if.y_pos, want.y_pos);
          end
        end
        pos_seen++;
        pos_stall = draw_gap(pos_calm);
      end else if (pos_stall > 0) begin
        pos_stall--;
      end
      pos_if.ready <= !hold_on && (pos_stall == 0);
    end
  end

  initial begin
    wait (cycles >= LIMIT_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    pos_if.ready = 1'b0;
    rx_cur = 8'h00;
    foreach (recent[i]) recent[i] = 8'h00;
    build_stimulus();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (rx_plan_q.size() != 0 || rx_busy || pos_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
